// ----- src/wop_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the wheel odometry pose update block.
// No dependencies.

package wop_pkg;

    // configuration port
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_WHEEL_RADIUS    = 2'd0;
    localparam logic [1:0] REG_FORWARD_OFFSET  = 2'd1;
    localparam logic [1:0] REG_SIDEWAYS_OFFSET = 2'd2;

    // register reset values
    localparam logic [21:0] RADIUS_RESET   = 22'd90112;
    localparam logic [22:0] FWD_OFF_RESET  = 23'd204800;
    localparam logic [22:0] SIDE_OFF_RESET = 23'd350618;

    // pose reset values
    localparam logic [15:0] HEADING_RESET = 16'd24576;
    localparam logic [31:0] X_RESET       = 32'hFFD5_0000;
    localparam logic [31:0] Y_RESET       = 32'hFFC5_C000;

    // scale factors: pi/18000 in Q40 and 2^32/(2*pi)
    localparam logic [31:0] KRAD = 32'd191900981;
    localparam logic [31:0] KINV = 32'd683565276;

    // sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_ONE = 32'd1073741824;
    localparam logic [31:0] SC1     = 32'd1686629713;
    localparam logic [31:0] SC3     = 32'd693598668;
    localparam logic [31:0] SC5     = 32'd85569306;
    localparam logic [31:0] SC7     = 32'd5026995;
    localparam logic [31:0] SC9     = 32'd172271;

    // input commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    // main sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ISSUE = 8'b0000_0010,
        ST_MLO   = 8'b0000_0100,
        ST_MHI   = 8'b0000_1000,
        ST_MRND  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_WB    = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // program steps of one sample
    typedef enum logic [4:0] {
        P_TF0, P_TF1, P_TS0, P_TS1,
        P_SZ2, P_S7, P_S5, P_S3, P_S1, P_SS,
        P_KS, P_DS, P_LX, P_KF, P_DF, P_LY,
        P_GX0, P_GX1, P_GY0, P_GY1
    } step_t;

    // which sine is being worked out
    typedef enum logic [1:0] {
        SIN_CH, SIN_SM, SIN_CM
    } sin_sel_t;

    // product scaling
    typedef enum logic [1:0] {
        SH0, SH16, SH30, SH40
    } shift_t;

endpackage

// ----- src/wheel_odometry_pose_update.sv -----
`timescale 1ns / 1ps
// Top level of the wheel odometry pose update block.
// Depends on wop_pkg.
//
// Usage
// - input channel (in_valid/in_ready) carries one item per transfer: cmd selects a
//   sensor sample or a set pose
// - output channel (out_valid/out_ready) returns one pose per input item, in order
// - configuration registers sit on an APB-style port at byte addresses 0, 4 and 8;
//   write them only while the block is idle
// - a set pose item skips the arithmetic: it goes from idle straight to ST_OUT, which loads the output register
// - a sample item runs through one shared 32x32 multiplier (states ISSUE, MLO, MHI,
//   MRND and WB per product) and a radix-2 divider (ISSUE, DIV, WB per quotient);
//   with no heading change it skips the chord sine and both divisions
// - in_ready is high only while the sequencer is idle; one item at a time
// - the result sits in an output register, so the next item is taken while it
//   waits; a stalled receiver holds the sequencer only when a second result is due
// - reset loads the pose (-43.0, -58.25 inches, heading 135 degrees), clears the
//   encoder references and restores the default wheel geometry

module wheel_odometry_pose_update (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic signed [31:0]         forward_angle,
    input  logic signed [31:0]         sideways_angle,
    input  logic        [15:0]         heading,
    input  logic signed [31:0]         set_x,
    input  logic signed [31:0]         set_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         pos_x,
    output logic signed [31:0]         pos_y,
    output logic        [15:0]         pose_heading,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wop_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import wop_pkg::*;

    // control
    state_t     state_reg, state_next;
    step_t      pc_reg, pc_next;
    sin_sel_t   sin_sel_reg, sin_sel_next;

    // configuration
    logic [21:0] wheel_radius_reg;
    logic [22:0] forward_offset_reg;
    logic [22:0] sideways_offset_reg;

    // pose state
    logic [31:0] last_forward_reg, last_forward_next;
    logic [31:0] last_sideways_reg, last_sideways_next;
    logic [15:0] last_heading_reg, last_heading_next;
    logic [31:0] x_pos_reg, x_pos_next;
    logic [31:0] y_pos_reg, y_pos_next;

    // per-item working values
    logic [31:0] df_reg, df_next;
    logic [31:0] ds_reg, ds_next;
    logic [15:0] dh_reg, dh_next;
    logic [15:0] hd_reg, hd_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] tf_reg, tf_next;
    logic [63:0] ts_reg, ts_next;
    logic [63:0] lx_reg, lx_next;
    logic [63:0] ly_reg, ly_next;
    logic [30:0] z2_reg, z2_next;
    logic [31:0] t_reg, t_next;
    logic [32:0] ch_reg, ch_next;
    logic [31:0] sm_reg, sm_next;
    logic [31:0] cm_reg, cm_next;

    // shared multiplier
    logic [63:0] a_mag_reg, a_mag_next;
    logic [31:0] b_mag_reg, b_mag_next;
    logic        neg_reg, neg_next;
    shift_t      shift_reg, shift_next;
    logic        rnd_reg, rnd_next;
    logic [95:0] acc_reg, acc_next;

    // divider
    logic [55:0] num_reg, num_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_neg_reg, div_neg_next;

    // unit result
    logic [63:0] res_mag_reg, res_mag_next;
    logic        res_neg_reg, res_neg_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [15:0] pose_heading_reg, pose_heading_next;

    // combinational helpers
    logic [16:0] dh17;
    logic [16:0] mid17;
    logic [16:0] sin_ang;
    logic [15:0] sin_x;
    logic [30:0] sin_z;
    logic [15:0] dh_mag;
    logic [63:0] op_a;
    logic [32:0] op_b;
    shift_t      op_shift;
    logic        op_round;
    logic        op_div;
    logic [63:0] a_abs;
    logic [32:0] b_abs;
    logic [31:0] mul_half;
    logic [63:0] mul_pp;
    logic [95:0] rnd_add;
    logic [95:0] rnd_sum;
    logic [63:0] rnd_res;
    logic [16:0] div_shift;
    logic        div_ge;
    logic [15:0] rem_new;
    logic [55:0] num_new;
    logic [63:0] wb_val;
    logic [31:0] sin_clamp;
    logic [31:0] sin_val;
    logic [63:0] soff64;
    logic [63:0] foff64;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_WHEEL_RADIUS:    prdata = {10'd0, wheel_radius_reg};
            REG_FORWARD_OFFSET:  prdata = {9'd0, forward_offset_reg};
            REG_SIDEWAYS_OFFSET: prdata = {9'd0, sideways_offset_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_radius_reg    <= RADIUS_RESET;
            forward_offset_reg  <= FWD_OFF_RESET;
            sideways_offset_reg <= SIDE_OFF_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_WHEEL_RADIUS:    wheel_radius_reg    <= pwdata[21:0];
                REG_FORWARD_OFFSET:  forward_offset_reg  <= pwdata[22:0];
                REG_SIDEWAYS_OFFSET: sideways_offset_reg <= pwdata[22:0];
                default:             ;
            endcase
        end
    end

    // sine argument and reduction to the first quadrant
    assign dh17  = {dh_reg[15], dh_reg};
    assign mid17 = {hd_reg, 1'b0} - dh17;

    always_comb
    begin
        case (sin_sel_reg)
            SIN_CH:  sin_ang = dh17;
            SIN_SM:  sin_ang = mid17;
            SIN_CM:  sin_ang = mid17 + 17'h0_8000;
            default: sin_ang = dh17;
        endcase
    end

    assign sin_x  = sin_ang[15] ? (16'h8000 - {1'b0, sin_ang[14:0]})
                                : {1'b0, sin_ang[14:0]};
    assign sin_z  = {sin_x, 15'd0};
    assign dh_mag = dh_reg[15] ? (16'd0 - dh_reg) : dh_reg;

    // offsets as 64-bit signed values
    assign soff64 = {{41{sideways_offset_reg[22]}}, sideways_offset_reg};
    assign foff64 = {{41{forward_offset_reg[22]}}, forward_offset_reg};

    // operand selection for each program step
    always_comb
    begin
        op_a     = tmp_reg;
        op_b     = {1'b0, KRAD};
        op_shift = SH30;
        op_round = 1'b1;
        op_div   = 1'b0;
        case (pc_reg)
            P_TF0:
            begin
                op_a     = {{32{df_reg[31]}}, df_reg};
                op_b     = {11'd0, wheel_radius_reg};
                op_shift = SH0;
                op_round = 1'b0;
            end
            P_TF1, P_TS1:
            begin
                op_a     = tmp_reg;
                op_b     = {1'b0, KRAD};
                op_shift = SH40;
            end
            P_TS0:
            begin
                op_a     = {{32{ds_reg[31]}}, ds_reg};
                op_b     = {11'd0, wheel_radius_reg};
                op_shift = SH0;
                op_round = 1'b0;
            end
            P_SZ2:
            begin
                op_a     = {33'd0, sin_z};
                op_b     = {2'd0, sin_z};
                op_round = 1'b0;
            end
            P_S7:
            begin
                op_a     = {33'd0, z2_reg};
                op_b     = {1'b0, SC9};
                op_round = 1'b0;
            end
            P_S5, P_S3, P_S1:
            begin
                op_a     = {33'd0, z2_reg};
                op_b     = {1'b0, t_reg};
                op_round = 1'b0;
            end
            P_SS:
            begin
                op_a     = {33'd0, sin_z};
                op_b     = {1'b0, t_reg};
                op_round = 1'b0;
            end
            P_KS:
            begin
                op_a     = ts_reg;
                op_b     = {1'b0, KINV};
                op_shift = SH16;
            end
            P_KF:
            begin
                op_a     = tf_reg;
                op_b     = {1'b0, KINV};
                op_shift = SH16;
            end
            P_DS, P_DF:
            begin
                op_a   = tmp_reg;
                op_div = 1'b1;
            end
            P_LX:
            begin
                op_a = lx_reg;
                op_b = ch_reg;
            end
            P_LY:
            begin
                op_a = ly_reg;
                op_b = ch_reg;
            end
            P_GX0:
            begin
                op_a = ly_reg;
                op_b = {sm_reg[31], sm_reg};
            end
            P_GX1:
            begin
                op_a = lx_reg;
                op_b = {cm_reg[31], cm_reg};
            end
            P_GY0:
            begin
                op_a = ly_reg;
                op_b = {cm_reg[31], cm_reg};
            end
            P_GY1:
            begin
                op_a = lx_reg;
                op_b = {sm_reg[31], sm_reg};
            end
            default: ;
        endcase
    end

    assign a_abs = op_a[63] ? (64'd0 - op_a) : op_a;
    assign b_abs = op_b[32] ? (33'd0 - op_b) : op_b;

    // shared 32x32 multiplier, one half of the wide operand per cycle
    assign mul_half = (state_reg == ST_MHI) ? a_mag_reg[63:32] : a_mag_reg[31:0];
    assign mul_pp   = mul_half * b_mag_reg;

    // round to nearest and scale
    always_comb
    begin
        rnd_add = 96'd0;
        case (shift_reg)
            SH0:     rnd_add = 96'd0;
            SH16:    rnd_add[15] = rnd_reg;
            SH30:    rnd_add[29] = rnd_reg;
            SH40:    rnd_add[39] = rnd_reg;
            default: rnd_add = 96'd0;
        endcase
    end

    assign rnd_sum = acc_reg + rnd_add;

    always_comb
    begin
        case (shift_reg)
            SH0:     rnd_res = rnd_sum[63:0];
            SH16:    rnd_res = rnd_sum[79:16];
            SH30:    rnd_res = rnd_sum[93:30];
            SH40:    rnd_res = {8'd0, rnd_sum[95:40]};
            default: rnd_res = rnd_sum[63:0];
        endcase
    end

    // restoring divider, one quotient bit per cycle
    assign div_shift = {rem_reg, num_reg[55]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign rem_new   = div_ge ? 16'(div_shift - {1'b0, den_reg}) : div_shift[15:0];
    assign num_new   = {num_reg[54:0], div_ge};

    // signed result and sine clamp
    assign wb_val    = res_neg_reg ? (64'd0 - res_mag_reg) : res_mag_reg;
    assign sin_clamp = (wb_val > {32'd0, SIN_ONE}) ? SIN_ONE : wb_val[31:0];
    assign sin_val   = sin_ang[16] ? (32'd0 - sin_clamp) : sin_clamp;

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        pc_next            = pc_reg;
        sin_sel_next       = sin_sel_reg;
        last_forward_next  = last_forward_reg;
        last_sideways_next = last_sideways_reg;
        last_heading_next  = last_heading_reg;
        x_pos_next         = x_pos_reg;
        y_pos_next         = y_pos_reg;
        df_next            = df_reg;
        ds_next            = ds_reg;
        dh_next            = dh_reg;
        hd_next            = hd_reg;
        tmp_next           = tmp_reg;
        tf_next            = tf_reg;
        ts_next            = ts_reg;
        lx_next            = lx_reg;
        ly_next            = ly_reg;
        z2_next            = z2_reg;
        t_next             = t_reg;
        ch_next            = ch_reg;
        sm_next            = sm_reg;
        cm_next            = cm_reg;
        a_mag_next         = a_mag_reg;
        b_mag_next         = b_mag_reg;
        neg_next           = neg_reg;
        shift_next         = shift_reg;
        rnd_next           = rnd_reg;
        acc_next           = acc_reg;
        num_next           = num_reg;
        rem_next           = rem_reg;
        den_next           = den_reg;
        cnt_next           = cnt_reg;
        div_neg_next       = div_neg_reg;
        res_mag_next       = res_mag_reg;
        res_neg_next       = res_neg_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        pose_heading_next  = pose_heading_reg;

        // output transfer frees the output register
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hd_next = heading;
                    last_heading_next = heading;
                    if (cmd == CMD_SET)
                    begin
                        x_pos_next = set_x;
                        y_pos_next = set_y;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        df_next            = forward_angle - last_forward_reg;
                        ds_next            = sideways_angle - last_sideways_reg;
                        dh_next            = heading - last_heading_reg;
                        last_forward_next  = forward_angle;
                        last_sideways_next = sideways_angle;
                        pc_next            = P_TF0;
                        state_next         = ST_ISSUE;
                    end
                end
            end

            ST_ISSUE:
            begin
                a_mag_next   = a_abs;
                b_mag_next   = b_abs[31:0];
                neg_next     = op_a[63] ^ op_b[32];
                shift_next   = op_shift;
                rnd_next     = op_round;
                num_next     = a_abs[55:0] + {41'd0, dh_mag[15:1]};
                rem_next     = 16'd0;
                den_next     = dh_mag;
                cnt_next     = 6'd0;
                div_neg_next = op_a[63] ^ dh_reg[15];
                state_next   = op_div ? ST_DIV : ST_MLO;
            end

            ST_MLO:
            begin
                acc_next   = {32'd0, mul_pp};
                state_next = ST_MHI;
            end

            ST_MHI:
            begin
                acc_next   = acc_reg + {mul_pp, 32'd0};
                state_next = ST_MRND;
            end

            ST_MRND:
            begin
                res_mag_next = rnd_res;
                res_neg_next = neg_reg;
                state_next   = ST_WB;
            end

            ST_DIV:
            begin
                rem_next = rem_new;
                num_next = num_new;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd55)
                begin
                    res_mag_next = {8'd0, num_new};
                    res_neg_next = div_neg_reg;
                    state_next   = ST_WB;
                end
            end

            ST_WB:
            begin
                state_next = ST_ISSUE;
                case (pc_reg)
                    P_TF0:
                    begin
                        tmp_next = wb_val;
                        pc_next  = P_TF1;
                    end
                    P_TF1:
                    begin
                        tf_next = wb_val;
                        pc_next = P_TS0;
                    end
                    P_TS0:
                    begin
                        tmp_next = wb_val;
                        pc_next  = P_TS1;
                    end
                    P_TS1:
                    begin
                        ts_next = wb_val;
                        pc_next = P_SZ2;
                        // straight move: the travel becomes the local displacement without the chord correction
                        if (dh_reg == 16'd0)
                        begin
                            lx_next      = wb_val;
                            ly_next      = tf_reg;
                            sin_sel_next = SIN_SM;
                        end
                        else
                        begin
                            sin_sel_next = SIN_CH;
                        end
                    end
                    P_SZ2:
                    begin
                        z2_next = wb_val[30:0];
                        pc_next = P_S7;
                    end
                    P_S7:
                    begin
                        t_next  = SC7 - wb_val[31:0];
                        pc_next = P_S5;
                    end
                    P_S5:
                    begin
                        t_next  = SC5 - wb_val[31:0];
                        pc_next = P_S3;
                    end
                    P_S3:
                    begin
                        t_next  = SC3 - wb_val[31:0];
                        pc_next = P_S1;
                    end
                    P_S1:
                    begin
                        t_next  = SC1 - wb_val[31:0];
                        pc_next = P_SS;
                    end
                    P_SS:
                    begin
                        case (sin_sel_reg)
                            SIN_CH:
                            begin
                                ch_next = {sin_val, 1'b0};
                                pc_next = P_KS;
                            end
                            SIN_SM:
                            begin
                                sm_next      = sin_val;
                                sin_sel_next = SIN_CM;
                                pc_next      = P_SZ2;
                            end
                            default:
                            begin
                                cm_next = sin_val;
                                pc_next = P_GX0;
                            end
                        endcase
                    end
                    P_KS:
                    begin
                        tmp_next = wb_val;
                        pc_next  = P_DS;
                    end
                    P_DS:
                    begin
                        lx_next = wb_val + soff64;
                        pc_next = P_LX;
                    end
                    P_LX:
                    begin
                        lx_next = wb_val;
                        pc_next = P_KF;
                    end
                    P_KF:
                    begin
                        tmp_next = wb_val;
                        pc_next  = P_DF;
                    end
                    P_DF:
                    begin
                        ly_next = wb_val - foff64;
                        pc_next = P_LY;
                    end
                    P_LY:
                    begin
                        ly_next      = wb_val;
                        sin_sel_next = SIN_SM;
                        pc_next      = P_SZ2;
                    end
                    P_GX0:
                    begin
                        x_pos_next = x_pos_reg + wb_val[31:0];
                        pc_next    = P_GX1;
                    end
                    P_GX1:
                    begin
                        x_pos_next = x_pos_reg + wb_val[31:0];
                        pc_next    = P_GY0;
                    end
                    P_GY0:
                    begin
                        y_pos_next = y_pos_reg + wb_val[31:0];
                        pc_next    = P_GY1;
                    end
                    P_GY1:
                    begin
                        y_pos_next = y_pos_reg - wb_val[31:0];
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_OUT:
            begin
                // wait here only while an earlier result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    pos_x_next        = x_pos_reg;
                    pos_y_next        = y_pos_reg;
                    pose_heading_next = hd_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pc_reg            <= P_TF0;
            sin_sel_reg       <= SIN_CH;
            out_valid_reg     <= 1'b0;
            last_forward_reg  <= 32'd0;
            last_sideways_reg <= 32'd0;
            last_heading_reg  <= HEADING_RESET;
            x_pos_reg         <= X_RESET;
            y_pos_reg         <= Y_RESET;
        end
        else
        begin
            state_reg         <= state_next;
            pc_reg            <= pc_next;
            sin_sel_reg       <= sin_sel_next;
            out_valid_reg     <= out_valid_next;
            last_forward_reg  <= last_forward_next;
            last_sideways_reg <= last_sideways_next;
            last_heading_reg  <= last_heading_next;
            x_pos_reg         <= x_pos_next;
            y_pos_reg         <= y_pos_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        df_reg           <= df_next;
        ds_reg           <= ds_next;
        dh_reg           <= dh_next;
        hd_reg           <= hd_next;
        tmp_reg          <= tmp_next;
        tf_reg           <= tf_next;
        ts_reg           <= ts_next;
        lx_reg           <= lx_next;
        ly_reg           <= ly_next;
        z2_reg           <= z2_next;
        t_reg            <= t_next;
        ch_reg           <= ch_next;
        sm_reg           <= sm_next;
        cm_reg           <= cm_next;
        a_mag_reg        <= a_mag_next;
        b_mag_reg        <= b_mag_next;
        neg_reg          <= neg_next;
        shift_reg        <= shift_next;
        rnd_reg          <= rnd_next;
        acc_reg          <= acc_next;
        num_reg          <= num_next;
        rem_reg          <= rem_next;
        den_reg          <= den_next;
        cnt_reg          <= cnt_next;
        div_neg_reg      <= div_neg_next;
        res_mag_reg      <= res_mag_next;
        res_neg_reg      <= res_neg_next;
        pos_x_reg        <= pos_x_next;
        pos_y_reg        <= pos_y_next;
        pose_heading_reg <= pose_heading_next;
    end

    // ports
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pose_heading = pose_heading_reg;

endmodule

// ----- src/wop_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the wheel odometry pose update block, bound to its top level.
// Depends on wop_pkg and wheel_odometry_pose_update.

module wop_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       cmd,
    input logic signed [31:0]         forward_angle,
    input logic signed [31:0]         sideways_angle,
    input logic        [15:0]         heading,
    input logic signed [31:0]         set_x,
    input logic signed [31:0]         set_y,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [31:0]         pos_x,
    input logic signed [31:0]         pos_y,
    input logic        [15:0]         pose_heading,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [wop_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);

    import wop_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(pos_x) && $stable(pos_y) && $stable(pose_heading)))
        else $error("result changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // set pose with a free output register echoes the loaded pose and heading
    a_set_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == CMD_SET) && !out_valid) |=> ##1
            (out_valid && pos_x == $past(set_x, 2) && pos_y == $past(set_y, 2)
             && pose_heading == $past(heading, 2)))
        else $error("set pose result wrong");

endmodule

bind wheel_odometry_pose_update wop_checker u_wop_checker (.*);
